FILE: hw/rtl/hdrdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrdf_pkg
// Shared types and constants of the header/length/footer deframer.
// ----------------------------------------------------------------------------
package hdrdf_pkg;

	// Frame framing bytes and the length overhead (command plus footer).
	localparam logic [7:0] HDR_BYTE     = 8'hFE;
	localparam logic [7:0] FTR_BYTE     = 8'hFA;
	localparam logic [7:0] LEN_OVERHEAD = 8'd2;

	// Configuration register indexes.
	localparam int         CFG_IDX_W           = 1;
	localparam logic [0:0] CFG_EXPECTED_COMMAND = 1'd0;
	localparam logic [0:0] CFG_MATCH_ANY        = 1'd1;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	// Parser phases, one-hot.
	typedef enum logic [5:0] {
		PH_HUNT1 = 6'b000001,
		PH_HUNT2 = 6'b000010,
		PH_LEN   = 6'b000100,
		PH_CMD   = 6'b001000,
		PH_DATA  = 6'b010000,
		PH_FOOT  = 6'b100000
	} phase_t;

	// Configuration as seen by the parser.
	typedef struct packed {
		logic [7:0] expected_command;
		logic       match_any;
	} cfg_t;

	// One result item.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] command;
		logic [7:0] payload_length;
		logic       last;
	} res_t;

endpackage

FILE: hw/rtl/header_length_footer_deframer_top.sv
`timescale 1ns / 1ps
// Timing: with the buffer empty, a result item is offered the cycle after its byte.
// Throughput: one byte per cycle; the output register plus one skid entry keep
// input acceptance going while a result waits, stalling input only when both hold items.
// Reset: arst_n clears the parser to header hunting, empties the output buffer
// and sets expected_command to 0 and match_any to 1.
// ----------------------------------------------------------------------------
// header_length_footer_deframer_top
// Recognizes length-prefixed frames in a byte stream and reports payload and end items.
// ----------------------------------------------------------------------------
module header_length_footer_deframer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      kind,
	output logic [7:0]                      data_byte,
	output logic [7:0]                      command,
	output logic [7:0]                      payload_length,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hdrdf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data
);
	import hdrdf_pkg::*;

	cfg_t cfg;
	res_t res, out_res;
	logic res_valid;
	logic in_take;
	logic full;

	assign in_stall = full;
	assign in_take  = in_valid && !in_stall;

	// Configuration registers.
	hdrdf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Frame parser.
	hdrdf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (in_take),
		.rx_byte   (rx_byte),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register and skid entry.
	hdrdf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign kind           = out_res.kind;
	assign data_byte      = out_res.data_byte;
	assign command        = out_res.command;
	assign payload_length = out_res.payload_length;
	assign last           = out_res.last;

endmodule

FILE: hw/rtl/hdrdf_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrdf_cfg
// Configuration registers, written through a valid/ready port.
// ----------------------------------------------------------------------------
module hdrdf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hdrdf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	output hdrdf_pkg::cfg_t               cfg
);
	import hdrdf_pkg::*;

	logic [7:0] expected_command_q;
	logic       match_any_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;

	// Register file update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_command_q <= 8'd0;
			match_any_q        <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_EXPECTED_COMMAND: expected_command_q <= cfg_data;
				CFG_MATCH_ANY:        match_any_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.expected_command = expected_command_q;
	assign cfg.match_any        = match_any_q;

endmodule

FILE: hw/rtl/hdrdf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrdf_parser
// Frame parser state machine; turns each accepted byte into zero or one result.
// ----------------------------------------------------------------------------
module hdrdf_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_take,
	input  logic [7:0]      rx_byte,
	input  hdrdf_pkg::cfg_t cfg,
	output logic            res_valid,
	output hdrdf_pkg::res_t res
);
	import hdrdf_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] remain_q, remain_d;
	logic [7:0] flen_q, flen_d;
	logic [7:0] cmd_q, cmd_d;
	logic       sel_q, sel_d;
	logic [7:0] remain_dec;

	assign remain_dec = remain_q - 8'd1;

	// Next-state and result logic for one byte.
	always_comb begin
		phase_d   = phase_q;
		remain_d  = remain_q;
		flen_d    = flen_q;
		cmd_d     = cmd_q;
		sel_d     = sel_q;
		res_valid = 1'b0;
		res.kind           = KIND_DATA;
		res.data_byte      = 8'd0;
		res.command        = cmd_q;
		res.payload_length = flen_q - LEN_OVERHEAD;
		res.last           = 1'b0;
		if (in_take) begin
			unique case (phase_q)
				PH_HUNT2: begin
					phase_d = (rx_byte == HDR_BYTE) ? PH_LEN : PH_HUNT1;
				end
				PH_LEN: begin
					if (rx_byte < LEN_OVERHEAD) begin
						phase_d = PH_HUNT1;
					end else begin
						flen_d   = rx_byte;
						remain_d = rx_byte - LEN_OVERHEAD;
						phase_d  = PH_CMD;
					end
				end
				PH_CMD: begin
					cmd_d   = rx_byte;
					sel_d   = cfg.match_any || (rx_byte == cfg.expected_command);
					phase_d = (remain_q != 8'd0) ? PH_DATA : PH_FOOT;
				end
				PH_DATA: begin
					res_valid     = sel_q;
					res.data_byte = rx_byte;
					remain_d      = remain_dec;
					if (remain_dec == 8'd0) begin
						phase_d = PH_FOOT;
					end
				end
				PH_FOOT: begin
					res_valid = sel_q;
					res.kind  = (rx_byte == FTR_BYTE) ? KIND_GOOD : KIND_BAD;
					res.last  = 1'b1;
					phase_d   = PH_HUNT1;
				end
				default: begin
					phase_d = (rx_byte == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
				end
			endcase
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT1;
			remain_q <= 8'd0;
			flen_q   <= 8'd0;
			cmd_q    <= 8'd0;
			sel_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			flen_q   <= flen_d;
			cmd_q    <= cmd_d;
			sel_q    <= sel_d;
		end
	end

endmodule

FILE: hw/rtl/hdrdf_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrdf_out_buf
// Output register with one skid entry, so input and output stall decouple.
// ----------------------------------------------------------------------------
module hdrdf_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hdrdf_pkg::res_t push_res,
	output logic            full,
	output logic            out_valid,
	input  logic            out_stall,
	output hdrdf_pkg::res_t out_res
);
	import hdrdf_pkg::*;

	res_t       head_q, skid_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = (cnt_q != 2'd0) && !out_stall;
	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_res   = head_q;

	// Item count; a push never arrives while full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Payload movement between the skid entry and the head.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= push_res;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_res;
			end else begin
				skid_q <= push_res;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q != 2'd2)
		else $error("item pushed into full output buffer");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cnt_q == 2'd2) |=> (out_valid && cnt_q == 2'd1))
		else $error("skid entry not moved to head");

endmodule
